/* src/simplex_tableau_solver_core_defines.svh */
// assertion macros for the port-level checker
`ifndef SIMPLEX_TABLEAU_SOLVER_CORE_DEFINES_SVH
`define SIMPLEX_TABLEAU_SOLVER_CORE_DEFINES_SVH

// clocked assertion with reset held off
`define STSOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same, with no reset qualifier
`define STSOL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/stsol_pkg.sv */
// shared types, constants and helper functions of the simplex tableau solver
package stsol_pkg;

  localparam int MAX_VARS  = 8;
  localparam int MAX_CONS  = 8;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int FIELD_W   = 4;
  localparam int ITER_W    = 8;
  localparam int NCOL      = MAX_VARS + MAX_CONS + 1;
  localparam int NROW      = MAX_CONS + 1;
  localparam int DEPTH     = NROW * NCOL;
  localparam int RHS_COL   = MAX_VARS + MAX_CONS;
  localparam int OBJ_ROW   = MAX_CONS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ROW_W     = $clog2(NROW);
  localparam int COL_W     = $clog2(NCOL + 1);
  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] QONE    = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_VARS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CONS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd2;

  typedef enum logic [1:0] {
    STAT_OPTIMAL   = 2'd0,
    STAT_UNBOUNDED = 2'd1,
    STAT_ITER_LIM  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SLACK, S_PC_RD, S_PC_CHK, S_PC_DEC,
    S_RT_E, S_RT_EC, S_RT_R, S_RT_DIV, S_RT_WAIT, S_RT_DEC,
    S_PE_RD, S_PE_LAT, S_NR_RD, S_NR_DIV, S_NR_WAIT,
    S_EL_ROW, S_EL_M, S_EL_RP, S_EL_RA, S_EL_WR,
    S_ITER, S_FIN_RD, S_FIN_LAT, S_FIN_OUT
  } state_e;

  // request to the shared divider
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  // answer of the shared divider
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(NCOL)) + ADDR_W'(c);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_wide(logic signed [2*DATA_W-1:0] x);
    logic signed [2*DATA_W-1:0] hi;
    logic signed [2*DATA_W-1:0] lo;
    hi = (2*DATA_W)'(SAT_MAX);
    lo = (2*DATA_W)'(SAT_MIN);
    if (x > hi) sat_wide = SAT_MAX;
    else if (x < lo) sat_wide = SAT_MIN;
    else sat_wide = x[DATA_W-1:0];
  endfunction

endpackage

/* src/stsol_ram.sv */
// generic single write, single read memory with registered read data
module stsol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 153
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/stsol_div.sv */
// bit-serial signed fixed point divider, one quotient bit a cycle, saturating
module stsol_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stsol_pkg::div_req_t req_i,
  output stsol_pkg::div_rsp_t rsp_o
);

  localparam int DW = stsol_pkg::DATA_W;
  localparam int QW = stsol_pkg::DIV_W;
  localparam logic [QW-1:0] LIM = QW'(1) << (DW - 1);

  logic                             busy_q;
  logic                             done_q;
  logic [stsol_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [DW:0]                      rem_q;
  logic [QW-1:0]                    dvd_q;
  logic [DW-1:0]                    den_q;
  logic                             neg_q;
  logic signed [DW-1:0]             quot_q;
  logic [DW-1:0]                    num_mag;
  logic [DW-1:0]                    den_mag;
  logic [DW:0]                      shifted;
  logic                             fits;
  logic signed [DW-1:0]             sat_q;

  assign num_mag = req_i.num[DW-1] ? DW'(-req_i.num) : DW'(req_i.num);
  assign den_mag = req_i.den[DW-1] ? DW'(-req_i.den) : DW'(req_i.den);
  assign shifted = {rem_q[DW-1:0], dvd_q[QW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  // saturate the magnitude quotient into the signed result
  always_comb begin
    if (neg_q) begin
      sat_q = (dvd_q > LIM) ? stsol_pkg::SAT_MIN : DW'(-dvd_q[DW-1:0]);
    end else begin
      sat_q = (dvd_q > LIM - QW'(1)) ? stsol_pkg::SAT_MAX : dvd_q[DW-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.valid) begin
        if (req_i.den == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= stsol_pkg::DIV_CNT_W'(QW);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      rem_q  <= '0;
      dvd_q  <= {num_mag, {stsol_pkg::FRAC_BITS{1'b0}}};
      den_q  <= den_mag;
      neg_q  <= req_i.num[DW-1] ^ req_i.den[DW-1];
      quot_q <= '0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        quot_q <= sat_q;
      end else begin
        rem_q <= fits ? shifted - {1'b0, den_q} : shifted;
        dvd_q <= {dvd_q[QW-2:0], fits};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

/* src/simplex_tableau_solver_core.sv */
// top level of the simplex tableau solver
//
// Input channel (valid/ready): one tableau element per beat, row/col/value.
// A row equal to the constraint count addresses the objective row and a
// column equal to the variable count the right-hand side; out-of-problem
// elements are dropped. Load beats are taken one per cycle.
// A beat with last set is loaded and then starts the solve; in_ready_o stays
// low until the result has been placed in the output register. The slack
// identity is inserted by the block.
// Solve time is set by the shared 48-step divider, which computes every ratio
// of the ratio test and every element of the normalised pivot row.
// Output channel (valid/ready): one beat per solve with status, objective and
// iteration count. A stalled receiver holds the result; the next problem can
// still be loaded and solved, but its final step waits for the output register.
// The tableau is cleared as the result is placed in the output register.
// Reset clears the tableau and sets one variable, one constraint and an
// iteration cap of 64. Configuration writes take effect at once, with no
// handshake.
module simplex_tableau_solver_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [stsol_pkg::FIELD_W-1:0]        in_row_i,
  input  logic [stsol_pkg::FIELD_W-1:0]        in_col_i,
  input  logic signed [stsol_pkg::DATA_W-1:0]  in_value_i,
  input  logic                                 in_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           out_status_o,
  output logic signed [stsol_pkg::DATA_W-1:0]  out_objective_o,
  output logic [stsol_pkg::ITER_W-1:0]         out_iterations_o,
  input  logic                                 cfg_we_i,
  input  logic [stsol_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [stsol_pkg::ITER_W-1:0]         cfg_data_i
);

  localparam int DW = stsol_pkg::DATA_W;
  localparam int FW = stsol_pkg::FIELD_W;
  localparam int CW = stsol_pkg::COL_W;
  localparam int RW = stsol_pkg::ROW_W;
  localparam int AW = stsol_pkg::ADDR_W;
  localparam logic [RW-1:0] OBJ_R = RW'(stsol_pkg::OBJ_ROW);
  localparam logic [CW-1:0] RHS_C = CW'(stsol_pkg::RHS_COL);

  stsol_pkg::state_e  state_q, state_d;
  stsol_pkg::status_e status_q;

  logic [FW-1:0]                nv_q, nc_q;
  logic [stsol_pkg::ITER_W-1:0] maxit_q, iter_q;
  logic [FW-1:0]                nv, nc;
  logic [CW-1:0]                ncols;

  logic [CW-1:0]        k_q, pc_q, col_k, col_kr;
  logic [RW-1:0]        i_q, pr_q;
  logic                 found_q;
  logic signed [DW-1:0] best_q, minr_q, e_q, pe_q, m_q, obj_q;
  logic signed [2*DW-1:0] prod_q, mul_full;

  logic                 out_valid_q;
  stsol_pkg::status_e   out_status_q;
  logic signed [DW-1:0] out_obj_q;
  logic [stsol_pkg::ITER_W-1:0] out_iter_q;

  logic [stsol_pkg::DEPTH-1:0] vld_q;
  logic [AW-1:0]        raddr_q;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DW-1:0]        ram_wdata, ram_rdata;
  logic signed [DW-1:0] rd_val;

  stsol_pkg::div_req_t  div_req;
  stsol_pkg::div_rsp_t  div_rsp;

  logic                 in_fire, load_ok, out_free, fin_fire;
  logic [RW-1:0]        load_r;
  logic [CW-1:0]        load_c;
  logic                 k_last, kr_last, i_last, row_last, el_skip;
  logic signed [DW-1:0] qm, el_new;

  // clamp the problem size registers
  always_comb begin
    nv = (nv_q == '0) ? FW'(1) : ((nv_q > FW'(stsol_pkg::MAX_VARS)) ?
         FW'(stsol_pkg::MAX_VARS) : nv_q);
    nc = (nc_q == '0) ? FW'(1) : ((nc_q > FW'(stsol_pkg::MAX_CONS)) ?
         FW'(stsol_pkg::MAX_CONS) : nc_q);
  end
  assign ncols = CW'(nv) + CW'(nc);

  // column list: decision variables, then the slack columns in use
  assign col_k  = (k_q < CW'(nv)) ? k_q : CW'(stsol_pkg::MAX_VARS) + k_q - CW'(nv);
  assign col_kr = (k_q == ncols) ? RHS_C : col_k;

  assign k_last   = (k_q == ncols - CW'(1));
  assign kr_last  = (k_q == ncols);
  assign i_last   = (i_q == RW'(nc) - RW'(1));
  assign row_last = (i_q == OBJ_R);
  assign el_skip  = (i_q == pr_q) || ((i_q >= RW'(nc)) && (i_q != OBJ_R));

  // input handshake and load decode
  assign in_ready_o = (state_q == stsol_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_ok    = (in_row_i <= nc) && (in_col_i <= nv) &&
                      !((in_row_i == nc) && (in_col_i == nv));
  assign load_r     = (in_row_i == nc) ? OBJ_R : RW'(in_row_i);
  assign load_c     = (in_col_i == nv) ? RHS_C : CW'(in_col_i);

  assign out_free = !out_valid_q || out_ready_i;
  assign fin_fire = (state_q == stsol_pkg::S_FIN_OUT) && out_free;

  // tableau read data, never-written cells read as zero
  assign rd_val = vld_q[raddr_q] ? ram_rdata : '0;

  // product and row update arithmetic
  assign mul_full = (2*DW)'(m_q) * (2*DW)'(rd_val);
  assign qm       = stsol_pkg::sat_wide(prod_q >>> stsol_pkg::FRAC_BITS);
  assign el_new   = stsol_pkg::sat_wide((2*DW)'(rd_val) - (2*DW)'(qm));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stsol_pkg::S_IDLE:    if (in_fire && in_last_i) state_d = stsol_pkg::S_SLACK;
      stsol_pkg::S_SLACK:   if (i_last) state_d = stsol_pkg::S_PC_RD;
      stsol_pkg::S_PC_RD:   state_d = stsol_pkg::S_PC_CHK;
      stsol_pkg::S_PC_CHK:  state_d = k_last ? stsol_pkg::S_PC_DEC : stsol_pkg::S_PC_RD;
      stsol_pkg::S_PC_DEC: begin
        if (best_q <= 0 || iter_q >= maxit_q) state_d = stsol_pkg::S_FIN_RD;
        else state_d = stsol_pkg::S_RT_E;
      end
      stsol_pkg::S_RT_E:    state_d = stsol_pkg::S_RT_EC;
      stsol_pkg::S_RT_EC: begin
        if (rd_val > 0) state_d = stsol_pkg::S_RT_R;
        else state_d = i_last ? stsol_pkg::S_RT_DEC : stsol_pkg::S_RT_E;
      end
      stsol_pkg::S_RT_R:    state_d = stsol_pkg::S_RT_DIV;
      stsol_pkg::S_RT_DIV:  state_d = stsol_pkg::S_RT_WAIT;
      stsol_pkg::S_RT_WAIT: begin
        if (div_rsp.done) state_d = i_last ? stsol_pkg::S_RT_DEC : stsol_pkg::S_RT_E;
      end
      stsol_pkg::S_RT_DEC:  state_d = found_q ? stsol_pkg::S_PE_RD : stsol_pkg::S_FIN_RD;
      stsol_pkg::S_PE_RD:   state_d = stsol_pkg::S_PE_LAT;
      stsol_pkg::S_PE_LAT:  state_d = stsol_pkg::S_NR_RD;
      stsol_pkg::S_NR_RD:   state_d = stsol_pkg::S_NR_DIV;
      stsol_pkg::S_NR_DIV:  state_d = stsol_pkg::S_NR_WAIT;
      stsol_pkg::S_NR_WAIT: begin
        if (div_rsp.done) state_d = kr_last ? stsol_pkg::S_EL_ROW : stsol_pkg::S_NR_RD;
      end
      stsol_pkg::S_EL_ROW: begin
        if (!el_skip) state_d = stsol_pkg::S_EL_M;
        else if (row_last) state_d = stsol_pkg::S_ITER;
      end
      stsol_pkg::S_EL_M:    state_d = stsol_pkg::S_EL_RP;
      stsol_pkg::S_EL_RP:   state_d = stsol_pkg::S_EL_RA;
      stsol_pkg::S_EL_RA:   state_d = stsol_pkg::S_EL_WR;
      stsol_pkg::S_EL_WR: begin
        if (!kr_last) state_d = stsol_pkg::S_EL_RP;
        else state_d = row_last ? stsol_pkg::S_ITER : stsol_pkg::S_EL_ROW;
      end
      stsol_pkg::S_ITER:    state_d = stsol_pkg::S_PC_RD;
      stsol_pkg::S_FIN_RD:  state_d = stsol_pkg::S_FIN_LAT;
      stsol_pkg::S_FIN_LAT: state_d = stsol_pkg::S_FIN_OUT;
      stsol_pkg::S_FIN_OUT: if (out_free) state_d = stsol_pkg::S_IDLE;
      default:              state_d = stsol_pkg::S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    div_req     = '0;
    case (state_q)
      stsol_pkg::S_IDLE: begin
        ram_we    = in_fire && load_ok;
        ram_waddr = stsol_pkg::cell_addr(load_r, load_c);
        ram_wdata = in_value_i;
      end
      stsol_pkg::S_SLACK: begin
        ram_we    = 1'b1;
        ram_waddr = stsol_pkg::cell_addr(i_q, CW'(stsol_pkg::MAX_VARS) + CW'(i_q));
        ram_wdata = stsol_pkg::QONE;
      end
      stsol_pkg::S_PC_RD: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(OBJ_R, col_k);
      end
      stsol_pkg::S_RT_E: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(i_q, pc_q);
      end
      stsol_pkg::S_RT_R: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(i_q, RHS_C);
      end
      stsol_pkg::S_RT_DIV: begin
        div_req.valid = 1'b1;
        div_req.num   = rd_val;
        div_req.den   = e_q;
      end
      stsol_pkg::S_PE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(pr_q, pc_q);
      end
      stsol_pkg::S_NR_RD: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(pr_q, col_kr);
      end
      stsol_pkg::S_NR_DIV: begin
        div_req.valid = 1'b1;
        div_req.num   = rd_val;
        div_req.den   = pe_q;
      end
      stsol_pkg::S_NR_WAIT: begin
        ram_we    = div_rsp.done;
        ram_waddr = stsol_pkg::cell_addr(pr_q, col_kr);
        ram_wdata = div_rsp.quot;
      end
      stsol_pkg::S_EL_ROW: begin
        ram_re    = !el_skip;
        ram_raddr = stsol_pkg::cell_addr(i_q, pc_q);
      end
      stsol_pkg::S_EL_RP: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(pr_q, col_kr);
      end
      stsol_pkg::S_EL_RA: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(i_q, col_kr);
      end
      stsol_pkg::S_EL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = stsol_pkg::cell_addr(i_q, col_kr);
        ram_wdata = el_new;
      end
      stsol_pkg::S_FIN_RD: begin
        ram_re    = 1'b1;
        ram_raddr = stsol_pkg::cell_addr(OBJ_R, RHS_C);
      end
      default: ;
    endcase
  end

  // state, configuration, valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= stsol_pkg::S_IDLE;
      nv_q         <= FW'(1);
      nc_q         <= FW'(1);
      maxit_q      <= stsol_pkg::ITER_W'(64);
      iter_q       <= '0;
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= stsol_pkg::STAT_OPTIMAL;
      out_status_q <= stsol_pkg::STAT_OPTIMAL;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          stsol_pkg::REG_NUM_VARS: nv_q    <= cfg_data_i[FW-1:0];
          stsol_pkg::REG_NUM_CONS: nc_q    <= cfg_data_i[FW-1:0];
          stsol_pkg::REG_MAX_ITER: maxit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ram_we) vld_q[ram_waddr] <= 1'b1;
      if (state_q == stsol_pkg::S_PC_DEC) begin
        if (best_q <= 0) status_q <= stsol_pkg::STAT_OPTIMAL;
        else status_q <= stsol_pkg::STAT_ITER_LIM;
      end
      if (state_q == stsol_pkg::S_RT_DEC) status_q <= stsol_pkg::STAT_UNBOUNDED;
      if (state_q == stsol_pkg::S_ITER) iter_q <= iter_q + 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (fin_fire) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        vld_q        <= '0;
        iter_q       <= '0;
      end
    end
  end

  // sequencer datapath registers
  always_ff @(posedge clk_i) begin
    if (ram_re) raddr_q <= ram_raddr;
    case (state_q)
      stsol_pkg::S_IDLE:    i_q <= '0;
      stsol_pkg::S_SLACK: begin
        i_q <= i_q + 1'b1;
        k_q <= '0;
      end
      stsol_pkg::S_PC_CHK: begin
        if (k_q == '0 || rd_val > best_q) begin
          best_q <= rd_val;
          pc_q   <= col_k;
        end
        k_q <= k_q + 1'b1;
      end
      stsol_pkg::S_PC_DEC: begin
        i_q     <= '0;
        found_q <= 1'b0;
      end
      stsol_pkg::S_RT_EC: begin
        if (rd_val > 0) e_q <= rd_val;
        else if (!i_last) i_q <= i_q + 1'b1;
      end
      stsol_pkg::S_RT_WAIT: begin
        if (div_rsp.done) begin
          if (!found_q || div_rsp.quot < minr_q) begin
            pr_q   <= i_q;
            minr_q <= div_rsp.quot;
          end
          found_q <= 1'b1;
          if (!i_last) i_q <= i_q + 1'b1;
        end
      end
      stsol_pkg::S_PE_LAT: begin
        pe_q <= rd_val;
        k_q  <= '0;
      end
      stsol_pkg::S_NR_WAIT: begin
        if (div_rsp.done) begin
          if (kr_last) i_q <= '0;
          else k_q <= k_q + 1'b1;
        end
      end
      stsol_pkg::S_EL_ROW:  if (el_skip && !row_last) i_q <= i_q + 1'b1;
      stsol_pkg::S_EL_M: begin
        m_q <= rd_val;
        k_q <= '0;
      end
      stsol_pkg::S_EL_RA:   prod_q <= mul_full;
      stsol_pkg::S_EL_WR: begin
        if (!kr_last) k_q <= k_q + 1'b1;
        else if (!row_last) i_q <= i_q + 1'b1;
      end
      stsol_pkg::S_ITER:    k_q <= '0;
      stsol_pkg::S_FIN_LAT: obj_q <= stsol_pkg::sat_wide(-(2*DW)'(rd_val));
      stsol_pkg::S_FIN_OUT: begin
        if (out_free) begin
          out_obj_q  <= obj_q;
          out_iter_q <= iter_q;
        end
      end
      default: ;
    endcase
  end

  // tableau memory
  stsol_ram #(
    .WIDTH (DW),
    .DEPTH (stsol_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared divider for ratios and row normalising
  stsol_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_objective_o  = out_obj_q;
  assign out_iterations_o = out_iter_q;

endmodule

/* src/stsol_checker.sv */
// port-level checker for the simplex tableau solver, bound to the top level
`include "simplex_tableau_solver_core_defines.svh"

module stsol_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 in_last_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [1:0]                           out_status_o,
  input logic signed [stsol_pkg::DATA_W-1:0]  out_objective_o,
  input logic [stsol_pkg::ITER_W-1:0]         out_iterations_o
);

  // a waiting result beat is held
  `STSOL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_objective_o) && $stable(out_iterations_o) && $stable(out_status_o), "result beat dropped while stalled")

  // status is one of the three codes
  `STSOL_ASSERT(a_status_code, out_valid_o |-> out_status_o != 2'd3, "undefined status code")

  // a last beat starts a solve, so the input side closes
  `STSOL_ASSERT(a_last_closes, in_valid_i && in_ready_o && in_last_i |=> !in_ready_o, "input open after last beat")

  // a fresh result only appears while the input side is closed
  `STSOL_ASSERT(a_result_after_solve, $rose(out_valid_o) |-> $past(!in_ready_o), "result without a solve")

endmodule

bind simplex_tableau_solver_core stsol_checker u_stsol_checker (.*);

/* tb/sv/simplex_tableau_solver_core_checker.sv */
// bit-exact solve predictor and result scoreboard for the simplex tableau solver
`timescale 1ns / 100ps

module simplex_tableau_solver_core_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [stsol_pkg::FIELD_W-1:0]       in_row_i,
  input  logic [stsol_pkg::FIELD_W-1:0]       in_col_i,
  input  logic signed [stsol_pkg::DATA_W-1:0] in_value_i,
  input  logic                                in_last_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [1:0]                          out_status_i,
  input  logic signed [stsol_pkg::DATA_W-1:0] out_objective_i,
  input  logic [stsol_pkg::ITER_W-1:0]        out_iterations_i,
  input  logic                                cfg_we_i,
  input  logic [stsol_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [stsol_pkg::ITER_W-1:0]        cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam int DW  = stsol_pkg::DATA_W;
  localparam int IW  = stsol_pkg::ITER_W;
  localparam int NR  = stsol_pkg::NROW;
  localparam int NC  = stsol_pkg::NCOL;
  localparam int OBJ = stsol_pkg::OBJ_ROW;
  localparam int RHS = stsol_pkg::RHS_COL;

  typedef struct packed {
    stsol_pkg::status_e  status;
    logic signed [DW-1:0] objective;
    logic [IW-1:0]       iterations;
  } solve_result_t;

  solve_result_t           solve_results_q[$];
  logic signed [DW-1:0]    tab [NR][NC];
  logic [IW-1:0]           pivot_cnt;
  logic [3:0]              nv_reg;
  logic [3:0]              nc_reg;
  logic [IW-1:0]           cap_reg;

  function automatic logic signed [DW-1:0] sat32(longint x);
    if (x > longint'(stsol_pkg::SAT_MAX)) return stsol_pkg::SAT_MAX;
    if (x < longint'(stsol_pkg::SAT_MIN)) return stsol_pkg::SAT_MIN;
    return x[DW-1:0];
  endfunction

  // floor of the scaled product
  function automatic logic signed [DW-1:0] fx_mul(logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat32(p >>> stsol_pkg::FRAC_BITS);
  endfunction

  // truncating scaled quotient, zero on zero divisor
  function automatic logic signed [DW-1:0] fx_div(logic signed [DW-1:0] a,
                                                  logic signed [DW-1:0] b);
    if (b == 0) return '0;
    return sat32((longint'(a) * (longint'(1) << stsol_pkg::FRAC_BITS)) / longint'(b));
  endfunction

  function automatic int clamp_size(logic [3:0] v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_tableau();
    for (int r = 0; r < NR; r++)
      for (int c = 0; c < NC; c++) tab[r][c] = '0;
    pivot_cnt = '0;
  endfunction

  // full simplex run on the shadow tableau
  function automatic stsol_pkg::status_e run_simplex(int nv, int nc);
    int cols[NC];
    int ncols;
    int pc;
    int pr;
    int cc;
    logic signed [DW-1:0] best;
    logic signed [DW-1:0] minr;
    logic signed [DW-1:0] rt;
    logic signed [DW-1:0] pe;
    logic signed [DW-1:0] m;
    ncols = 0;
    for (int k = 0; k < nv; k++) begin
      cols[ncols] = k;
      ncols++;
    end
    for (int k = 0; k < nc; k++) begin
      cols[ncols] = stsol_pkg::MAX_VARS + k;
      ncols++;
    end
    for (int i = 0; i < nc; i++) tab[i][stsol_pkg::MAX_VARS + i] = stsol_pkg::QONE;
    while (1) begin
      // entering column: first largest objective entry
      pc = -1;
      best = '0;
      for (int k = 0; k < ncols; k++) begin
        if (pc < 0 || tab[OBJ][cols[k]] > best) begin
          pc = cols[k];
          best = tab[OBJ][cols[k]];
        end
      end
      if (best <= 0) return stsol_pkg::STAT_OPTIMAL;
      if (pivot_cnt >= cap_reg) return stsol_pkg::STAT_ITER_LIM;
      // leaving row: strict minimum ratio
      pr = -1;
      minr = '0;
      for (int i = 0; i < nc; i++) begin
        if (tab[i][pc] > 0) begin
          rt = fx_div(tab[i][RHS], tab[i][pc]);
          if (pr < 0 || rt < minr) begin
            pr = i;
            minr = rt;
          end
        end
      end
      if (pr < 0) return stsol_pkg::STAT_UNBOUNDED;
      // normalise pivot row
      pe = tab[pr][pc];
      for (int k = 0; k < ncols; k++) tab[pr][cols[k]] = fx_div(tab[pr][cols[k]], pe);
      tab[pr][RHS] = fx_div(tab[pr][RHS], pe);
      // eliminate pivot column elsewhere
      for (int i = 0; i < NR; i++) begin
        if (i == pr || (i >= nc && i != OBJ)) continue;
        m = tab[i][pc];
        for (int k = 0; k <= ncols; k++) begin
          cc = (k < ncols) ? cols[k] : RHS;
          tab[i][cc] = sat32(longint'(tab[i][cc]) - longint'(fx_mul(m, tab[pr][cc])));
        end
      end
      pivot_cnt = pivot_cnt + 1'b1;
    end
  endfunction

  // track config, load beats and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    int nv;
    int nc;
    int tr;
    int tc;
    solve_result_t want;
    solve_result_t got;
    if (!rst_ni) begin
      clear_tableau();
      nv_reg = 4'd1;
      nc_reg = 4'd1;
      cap_reg = 8'd64;
      solve_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // result beat against oldest expectation
      if (out_valid_i && out_ready_i) begin
        got.status = stsol_pkg::status_e'(out_status_i);
        got.objective = out_objective_i;
        got.iterations = out_iterations_i;
        if (solve_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] unexpected result beat: status %0d objective %h iterations %0d",
                     $realtime, got.status, got.objective, got.iterations);
        end else begin
          want = solve_results_q.pop_front();
          if (want != got) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display({"[%0t] result mismatch: expected status %0d objective %h ",
                        "iterations %0d, got status %0d objective %h iterations %0d"},
                       $realtime, want.status, want.objective, want.iterations,
                       got.status, got.objective, got.iterations);
          end
        end
      end
      // load beat, solve on last
      if (in_valid_i && in_ready_i) begin
        nv = clamp_size(nv_reg, stsol_pkg::MAX_VARS);
        nc = clamp_size(nc_reg, stsol_pkg::MAX_CONS);
        if (in_row_i <= nc && in_col_i <= nv && !(in_row_i == nc && in_col_i == nv)) begin
          tr = (in_row_i == nc) ? OBJ : in_row_i;
          tc = (in_col_i == nv) ? RHS : in_col_i;
          tab[tr][tc] = in_value_i;
        end
        if (in_last_i) begin
          want.status = run_simplex(nv, nc);
          want.objective = sat32(-longint'(tab[OBJ][RHS]));
          want.iterations = pivot_cnt;
          solve_results_q.push_back(want);
          clear_tableau();
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          stsol_pkg::REG_NUM_VARS: nv_reg = cfg_data_i[3:0];
          stsol_pkg::REG_NUM_CONS: nc_reg = cfg_data_i[3:0];
          stsol_pkg::REG_MAX_ITER: cap_reg = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = solve_results_q.size();
    end
  end

endmodule

/* tb/sv/simplex_tableau_solver_core_tb.sv */
// stimulus and verdict for the simplex tableau solver core
`timescale 1ns / 100ps

module simplex_tableau_solver_core_tb;

  localparam int ONE = 1 << stsol_pkg::FRAC_BITS;
  localparam int FW  = stsol_pkg::FIELD_W;
  localparam int DW  = stsol_pkg::DATA_W;
  localparam int IW  = stsol_pkg::ITER_W;
  localparam int XW  = stsol_pkg::CFG_IDX_W;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [FW-1:0]        in_row_i = '0;
  logic [FW-1:0]        in_col_i = '0;
  logic signed [DW-1:0] in_value_i = '0;
  logic                 in_last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           out_status_o;
  logic signed [DW-1:0] out_objective_o;
  logic [IW-1:0]        out_iterations_o;
  logic                 cfg_we_i = 1'b0;
  logic [XW-1:0]        cfg_index_i = '0;
  logic [IW-1:0]        cfg_data_i = '0;

  int  fail_count;
  int  pending;
  int  beats_sent;
  int  problems_sent;
  int  settings_used;
  int  cur_nv;
  int  cur_nc;
  bit  calm;

  always #6 clk_i = ~clk_i;

  simplex_tableau_solver_core dut (.*);

  simplex_tableau_solver_core_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_row_i, .in_col_i, .in_value_i, .in_last_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_status_i(out_status_o),
    .out_objective_i(out_objective_o), .out_iterations_i(out_iterations_o),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // one load beat, called at a rising edge
  task automatic send_beat(int r, int c, int v, bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_row_i   <= r[FW-1:0];
    in_col_i   <= c[FW-1:0];
    in_value_i <= v;
    in_last_i  <= last;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    beats_sent++;
    if (last) problems_sent++;
  endtask

  // hold off until every solve has been returned
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [XW-1:0] idx, int data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[IW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == stsol_pkg::REG_NUM_VARS)
      cur_nv = (data[3:0] == 0) ? 1 :
               (data[3:0] > stsol_pkg::MAX_VARS) ? stsol_pkg::MAX_VARS : data[3:0];
    if (idx == stsol_pkg::REG_NUM_CONS)
      cur_nc = (data[3:0] == 0) ? 1 :
               (data[3:0] > stsol_pkg::MAX_CONS) ? stsol_pkg::MAX_CONS : data[3:0];
  endtask

  task automatic set_sizes(int nv, int nc, int cap);
    reg_write(stsol_pkg::REG_NUM_VARS, nv);
    reg_write(stsol_pkg::REG_NUM_CONS, nc);
    reg_write(stsol_pkg::REG_MAX_ITER, cap);
    settings_used++;
  endtask

  // Q16.16 value with integer part in [lo, hi] and a random fraction now and then
  function automatic int qval(int lo, int hi);
    int frac;
    frac = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, ONE - 1)) : 0;
    return (lo + int'($urandom_range(0, hi - lo))) * ONE + frac;
  endfunction

  // well-formed problem with some stray beats mixed in
  task automatic send_problem();
    int nv;
    int nc;
    nv = cur_nv;
    nc = cur_nc;
    for (int r = 0; r <= nc; r++) begin
      for (int c = 0; c <= nv; c++) begin
        if (r == nc && c == nv) continue;
        if ($urandom_range(0, 11) == 0)
          send_beat($urandom_range(0, 15), $urandom_range(0, 15), $urandom, 1'b0);
        if (r < nc && c < nv && $urandom_range(0, 9) < 2) continue;
        if (r == nc)
          send_beat(r, c, qval(-2, 9), r == nc && c == nv - 1);
        else if (c == nv)
          send_beat(r, c, qval(0, 20), 1'b0);
        else
          send_beat(r, c, qval(-3, 8), 1'b0);
      end
    end
  endtask

  // result side stalls
  initial begin
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      @(posedge clk_i);
    end
  end

  initial begin
    int kind;
    cur_nv = 1;
    cur_nc = 1;
    calm = 1'b0;
    beats_sent = 0;
    problems_sent = 0;
    settings_used = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: one variable, one constraint
    send_beat(0, 0, ONE, 0);
    send_beat(0, 1, 4 * ONE, 0);
    send_beat(1, 0, 3 * ONE, 1);                 // bounded optimum
    send_beat(0, 0, -ONE, 0);
    send_beat(0, 1, 2 * ONE, 0);
    send_beat(1, 0, ONE, 1);                     // unbounded
    send_beat(1, 0, -ONE, 1);                    // optimal at start
    send_beat(1, 1, 5 * ONE, 1);                 // corner only, ignored
    send_beat(0, 0, 7 * ONE, 0);
    send_beat(15, 15, 32'hFFFF_FFFF, 0);         // outside the problem
    send_beat(0, 0, 2 * ONE, 0);                 // overwrite
    send_beat(0, 1, 32'h7FFF_FFFF, 0);
    send_beat(1, 0, 32'h7FFF_FFFF, 1);           // saturation
    send_beat(0, 0, 32'h8000_0000, 0);
    send_beat(0, 1, 32'h8000_0000, 0);
    send_beat(1, 0, 32'h0000_0001, 1);
    send_beat(0, 0, 1, 0);
    send_beat(0, 1, 32'h7FFF_FFFF, 0);
    send_beat(1, 0, ONE, 0);
    send_beat(15, 0, ONE, 1);                    // last on an ignored beat
    drain();

    // zero cap, then out-of-range sizes and the largest sizes
    set_sizes(1, 1, 0);
    send_beat(0, 0, ONE, 0);
    send_beat(0, 1, ONE, 0);
    send_beat(1, 0, ONE, 1);
    drain();
    set_sizes(0, 15, 1);
    send_problem();
    drain();
    set_sizes(15, 0, 255);
    send_problem();
    drain();
    set_sizes(8, 8, 3);
    send_problem();
    drain();

    // random phases
    while (beats_sent < 400) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 3) == 0);
      if (kind == 0)
        set_sizes(8, 8, $urandom_range(1, 4));
      else if (kind == 1)
        set_sizes($urandom_range(0, 1) ? 0 : 15, $urandom_range(0, 15), $urandom_range(1, 6));
      else
        set_sizes($urandom_range(1, 4), $urandom_range(1, 4),
                  (kind == 2) ? 255 : (kind == 3) ? 0 : $urandom_range(1, 40));
      repeat ((kind <= 1) ? 1 : $urandom_range(1, 4)) send_problem();
      drain();
    end
    calm = 1'b0;
    repeat (50) @(posedge clk_i);

    $display("coverage: %0d load beats, %0d solves, %0d register settings",
             beats_sent, problems_sent, settings_used);
    $display("sizes from one to eight, iteration caps from zero to 255, stray and corner beats");
    if (fail_count == 0 && pending == 0) begin
      $display("simplex_tableau_solver_core verification clean");
    end else begin
      $display("simplex_tableau_solver_core verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 40000000);
    $display("simplex_tableau_solver_core verification failed");
    $finish;
  end

endmodule

/* simplex_tableau_solver_core.f */
+incdir+src
src/stsol_pkg.sv
src/stsol_ram.sv
src/stsol_div.sv
src/simplex_tableau_solver_core.sv
src/stsol_checker.sv
tb/sv/simplex_tableau_solver_core_checker.sv
tb/sv/simplex_tableau_solver_core_tb.sv
